FILE: rtl/lcabl_pkg.sv
`timescale 1ns / 1ps

package lcabl_pkg;

    localparam int FIELD_W         = 10;
    localparam int CMD_W           = 2;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;
    localparam int RECIP_SHIFT     = 21;
    localparam int RECIP_W         = 22;

    localparam logic [FIELD_W-1:0] ROOT_RESET = FIELD_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

endpackage

FILE: rtl/lcabl_node_reduce.sv
`timescale 1ns / 1ps

module lcabl_node_reduce #(
    parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
    parameter int NW        = $clog2(MAX_NODES)
) (
    input  logic                         i_clk,
    input  logic [lcabl_pkg::FIELD_W-1:0] i_value,
    output logic [NW-1:0]                o_node
);

    localparam int FW    = lcabl_pkg::FIELD_W;
    localparam int SH    = lcabl_pkg::RECIP_SHIFT;
    localparam int RW    = lcabl_pkg::RECIP_W;
    localparam int PW    = FW + RW;
    localparam int QW    = PW - SH;
    localparam longint RECIP = ((64'd1 << SH) + MAX_NODES - 1) / MAX_NODES;

    logic [FW-1:0] r_v;
    logic [QW-1:0] r_q;
    logic [NW-1:0] r_node;
    logic [PW-1:0] prod;
    logic [PW-1:0] rem;

    // quotient estimate by reciprocal, exact for ten-bit values
    assign prod = PW'(i_value) * PW'(RECIP);
    assign rem  = PW'(r_v) - (PW'(r_q) * PW'(MAX_NODES));

    always_ff @(posedge i_clk) begin
        r_v    <= i_value;
        r_q    <= prod[PW-1:SH];
        r_node <= rem[NW-1:0];
    end

    assign o_node = r_node;

endmodule

FILE: rtl/lcabl_ram.sv
`timescale 1ns / 1ps

module lcabl_ram #(
    parameter int WIDTH = lcabl_pkg::FIELD_W,
    parameter int DEPTH = lcabl_pkg::MAX_NODES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lca_binary_lifting.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// command   start, busy           i_command, i_node_index, i_parent_index,
//                                 i_node_depth, i_other_node
// result    o_valid (1 cycle)     o_common_ancestor
// config    i_cfg_we              i_cfg_wdata (root node)
//
// Load writes the parent and depth tables. Query reads both depths and lifts the
// deeper node level by level using ancestor and depth reads on the tables; unless
// the lifted node meets the other, it lifts both nodes together, then reads the
// parent. Build: two dependent reads and a write for each node and lift level.
// Reset is synchronous, active low; table contents are not cleared.
// The result receiver cannot stall; busy holds off new commands.

module lca_binary_lifting #(
    parameter int MAX_NODES   = lcabl_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = lcabl_pkg::LIFT_LEVELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lcabl_pkg::CMD_W-1:0]        i_command,
    input  logic [lcabl_pkg::FIELD_W-1:0]      i_node_index,
    input  logic [lcabl_pkg::FIELD_W-1:0]      i_parent_index,
    input  logic [lcabl_pkg::FIELD_W-1:0]      i_node_depth,
    input  logic [lcabl_pkg::FIELD_W-1:0]      i_other_node,
    input  logic                               i_cfg_we,
    input  logic [lcabl_pkg::FIELD_W-1:0]      i_cfg_wdata,
    output logic                               o_valid,
    output logic [lcabl_pkg::FIELD_W-1:0]      o_common_ancestor
);

    localparam int FW        = lcabl_pkg::FIELD_W;
    localparam int NW        = $clog2(MAX_NODES);
    localparam int LVW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int AW        = LVW + NW;
    localparam int ANC_DEPTH = LIFT_LEVELS << NW;

    localparam logic [LVW-1:0] LAST_LVL  = LVW'(LIFT_LEVELS - 1);
    localparam logic [NW-1:0]  LAST_NODE = NW'(MAX_NODES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_DISP,
        S_Q_DA, S_Q_DB,
        S_U_RD, S_U_DP, S_U_CMP, S_MEET,
        S_P_RA, S_P_RB, S_P_CMP,
        S_F_RD, S_F_OUT,
        S_B_RD1, S_B_RD2, S_B_WR
    } t_state;

    t_state              r_state, n_state;
    lcabl_pkg::t_cmd     r_cmd, n_cmd;
    logic [FW-1:0]       r_root;
    logic [FW-1:0]       r_depth, n_depth;
    logic [FW-1:0]       r_da, n_da;
    logic [FW-1:0]       r_db, n_db;
    logic [NW-1:0]       r_a, n_a;
    logic [NW-1:0]       r_b, n_b;
    logic [NW-1:0]       r_up, n_up;
    logic [NW-1:0]       r_n, n_n;
    logic [LVW-1:0]      r_lvl, n_lvl;
    logic                r_valid, n_valid;
    logic [FW-1:0]       r_ancestor, n_ancestor;

    logic [FW-1:0]       red_in_a, red_in_b;
    logic [NW-1:0]       red_a, red_b;

    logic                anc_we;
    logic [AW-1:0]       anc_waddr, anc_raddr;
    logic [NW-1:0]       anc_wdata, anc_rdata;
    logic                dep_we;
    logic [NW-1:0]       dep_waddr, dep_raddr;
    logic [FW-1:0]       dep_rdata;
    logic [LVW-1:0]      lvl_below;

    assign red_in_a = (i_command == lcabl_pkg::CMD_BUILD) ? r_root : i_node_index;
    assign red_in_b = (i_command == lcabl_pkg::CMD_LOAD) ? i_parent_index : i_other_node;
    assign lvl_below = LVW'(r_lvl - 1'b1);

    lcabl_node_reduce #(.MAX_NODES(MAX_NODES), .NW(NW)) u_red_a (
        .i_clk   (i_clk),
        .i_value (red_in_a),
        .o_node  (red_a)
    );

    lcabl_node_reduce #(.MAX_NODES(MAX_NODES), .NW(NW)) u_red_b (
        .i_clk   (i_clk),
        .i_value (red_in_b),
        .o_node  (red_b)
    );

    lcabl_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH), .AW(AW)) u_anc (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    lcabl_ram #(.WIDTH(FW), .DEPTH(MAX_NODES), .AW(NW)) u_depth (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (r_depth),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_depth    = r_depth;
        n_da       = r_da;
        n_db       = r_db;
        n_a        = r_a;
        n_b        = r_b;
        n_up       = r_up;
        n_n        = r_n;
        n_lvl      = r_lvl;
        n_valid    = 1'b0;
        n_ancestor = r_ancestor;
        anc_we     = 1'b0;
        anc_waddr  = {r_lvl, r_n};
        anc_wdata  = anc_rdata;
        anc_raddr  = {r_lvl, r_a};
        dep_we     = 1'b0;
        dep_waddr  = red_a;
        dep_raddr  = r_a;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = lcabl_pkg::t_cmd'(i_command);
                    n_depth = i_node_depth;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                n_state = S_DISP;
            end
            S_DISP: begin
                case (r_cmd)
                    lcabl_pkg::CMD_LOAD: begin
                        anc_we    = 1'b1;
                        anc_waddr = {{LVW{1'b0}}, red_a};
                        anc_wdata = red_b;
                        dep_we    = 1'b1;
                        n_state   = S_IDLE;
                    end
                    lcabl_pkg::CMD_BUILD: begin
                        anc_we    = 1'b1;
                        anc_waddr = {{LVW{1'b0}}, red_a};
                        anc_wdata = red_a;
                        n_lvl     = LVW'(1);
                        n_n       = '0;
                        n_state   = (LIFT_LEVELS > 1) ? S_B_RD1 : S_IDLE;
                    end
                    lcabl_pkg::CMD_QUERY: begin
                        n_a       = red_a;
                        n_b       = red_b;
                        dep_raddr = red_a;
                        n_state   = S_Q_DA;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_Q_DA: begin
                n_da      = dep_rdata;
                dep_raddr = r_b;
                n_state   = S_Q_DB;
            end
            S_Q_DB: begin
                if (r_da < dep_rdata) begin
                    n_a  = r_b;
                    n_b  = r_a;
                    n_db = r_da;
                end else begin
                    n_db = dep_rdata;
                end
                n_lvl   = LAST_LVL;
                n_state = S_U_RD;
            end
            S_U_RD: begin
                anc_raddr = {r_lvl, r_a};
                n_state   = S_U_DP;
            end
            S_U_DP: begin
                n_up      = anc_rdata;
                dep_raddr = anc_rdata;
                n_state   = S_U_CMP;
            end
            S_U_CMP: begin
                if (dep_rdata >= r_db) begin
                    n_a = r_up;
                end
                if (r_lvl == '0) begin
                    n_state = S_MEET;
                end else begin
                    n_lvl   = lvl_below;
                    n_state = S_U_RD;
                end
            end
            S_MEET: begin
                if (r_a == r_b) begin
                    n_valid    = 1'b1;
                    n_ancestor = FW'(r_a);
                    n_state    = S_IDLE;
                end else begin
                    n_lvl   = LAST_LVL;
                    n_state = S_P_RA;
                end
            end
            S_P_RA: begin
                anc_raddr = {r_lvl, r_a};
                n_state   = S_P_RB;
            end
            S_P_RB: begin
                n_up      = anc_rdata;
                anc_raddr = {r_lvl, r_b};
                n_state   = S_P_CMP;
            end
            S_P_CMP: begin
                if (r_up != anc_rdata) begin
                    n_a = r_up;
                    n_b = anc_rdata;
                end
                if (r_lvl == '0) begin
                    n_state = S_F_RD;
                end else begin
                    n_lvl   = lvl_below;
                    n_state = S_P_RA;
                end
            end
            S_F_RD: begin
                anc_raddr = {{LVW{1'b0}}, r_a};
                n_state   = S_F_OUT;
            end
            S_F_OUT: begin
                n_valid    = 1'b1;
                n_ancestor = FW'(anc_rdata);
                n_state    = S_IDLE;
            end
            S_B_RD1: begin
                anc_raddr = {lvl_below, r_n};
                n_state   = S_B_RD2;
            end
            S_B_RD2: begin
                anc_raddr = {lvl_below, anc_rdata};
                n_state   = S_B_WR;
            end
            S_B_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {r_lvl, r_n};
                anc_wdata = anc_rdata;
                if (r_n == LAST_NODE) begin
                    n_n = '0;
                    if (r_lvl == LAST_LVL) begin
                        n_state = S_IDLE;
                    end else begin
                        n_lvl   = LVW'(r_lvl + 1'b1);
                        n_state = S_B_RD1;
                    end
                end else begin
                    n_n     = NW'(r_n + 1'b1);
                    n_state = S_B_RD1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_root  <= lcabl_pkg::ROOT_RESET;
            r_lvl   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_lvl   <= n_lvl;
            r_n     <= n_n;
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
        end
        r_cmd      <= n_cmd;
        r_depth    <= n_depth;
        r_da       <= n_da;
        r_db       <= n_db;
        r_a        <= n_a;
        r_b        <= n_b;
        r_up       <= n_up;
        r_ancestor <= n_ancestor;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_common_ancestor = r_ancestor;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer still active");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_result_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cmd == lcabl_pkg::CMD_QUERY))
        else $error("result produced for a non-query transaction");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_lvl <= LAST_LVL))
        else $error("lift level out of range");

endmodule
